@@ rtl/core/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg: shared constants for the binary min-heap queue
// Heap capacity and the widths derived from it, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int ENTRY_W  = KEY_W + TAG_W;
  localparam int OCC_W    = 7;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_MIN      = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/bmhq_ram.sv @@
// ----------------------------------------------------------------------------
// bmhq_ram: generic RAM, one write port, two registered read ports
// Read data appears in the cycle after the address is presented.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         wa,
  input  wire logic [WIDTH-1:0]                 wd,
  input  wire logic [$clog2(DEPTH)-1:0]         ra0,
  input  wire logic [$clog2(DEPTH)-1:0]         ra1,
  output logic      [WIDTH-1:0]                 rd0,
  output logic      [WIDTH-1:0]                 rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

`default_nettype wire

@@ rtl/core/binary_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary_min_heap_queue: min-heap priority queue of key/tag pairs
// Beats on s_axis carry a command (s_axis_tuser) and a key/tag pair; each
// beat yields exactly one result beat on m_axis with a status code
// (m_axis_tuser), the removed minimum and the occupancy after the command.
// Insert appends the pair and sifts it up; extract moves the last entry to
// the root and sifts it down to the smaller child. Ties never swap.
// One sequencer drives signed key comparators and a RAM with two
// registered read ports, one heap level per cycle. Steps per beat:
//   insert         : S_UP climbs a level at a time, then S_FIN
//   extract        : S_DN_LOAD reads the root and the last entry, S_DOWN
//                    descends, then S_FIN; straight to S_FIN for the last entry
//   empty / full   : straight to S_FIN
// s_axis_tready is high only while the sequencer is idle, so one command is
// in flight at a time. A finished result is held in the output register;
// if it has not been taken, the next result waits until it is.
// Reset empties the heap at once (the count is cleared); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // key[31:0], tag[47:32]
  input  wire logic        s_axis_tuser,   // command[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [55:0] m_axis_tdata,   // min_key[31:0], min_tag[47:32],
                                           // occupancy[54:48], zero pad[55]
  output logic      [1:0]  m_axis_tuser    // status[1:0]
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_UP      = 5'b00010,
    S_DN_LOAD = 5'b00100,
    S_DOWN    = 5'b01000,
    S_FIN     = 5'b10000
  } state_t;

  localparam int CH_W = IDX_W + 2;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [KEY_W-1:0]   cur_key, cur_key_next;
  logic [TAG_W-1:0]   cur_tag, cur_tag_next;
  logic [1:0]         res_status, res_status_next;
  logic [KEY_W-1:0]   res_key, res_key_next;
  logic [TAG_W-1:0]   res_tag, res_tag_next;
  logic               out_load;

  logic               we;
  logic [IDX_W-1:0]   wa, ra0, ra1;
  logic [ENTRY_W-1:0] wd, rd0, rd1;

  logic [KEY_W-1:0]   in_key, rd0_key, rd1_key, child_key;
  logic [TAG_W-1:0]   in_tag;
  logic [IDX_W-1:0]   par_idx, par_cnt;
  logic [CH_W-1:0]    left, right, count_ext, left_m, right_m;
  logic               right_ok, pick_right;
  logic [IDX_W-1:0]   m_idx;

  assign in_key  = s_axis_tdata[KEY_W-1:0];
  assign in_tag  = s_axis_tdata[ENTRY_W-1:KEY_W];
  assign rd0_key = rd0[KEY_W-1:0];
  assign rd1_key = rd1[KEY_W-1:0];

  assign s_axis_tready = (state == S_IDLE);

  // heap index arithmetic
  assign par_idx   = (idx - 1'b1) >> 1;
  assign par_cnt   = IDX_W'((count - 1'b1) >> 1);
  assign left      = {1'b0, idx, 1'b1};
  assign right     = left + 1'b1;
  assign count_ext = CH_W'(count);
  assign right_ok  = right < count_ext;
  // right child only when it exists and is strictly smaller
  assign pick_right = right_ok && ($signed(rd1_key) < $signed(rd0_key));
  assign m_idx      = pick_right ? IDX_W'(right) : IDX_W'(left);
  assign child_key  = pick_right ? rd1_key : rd0_key;
  assign left_m     = {1'b0, m_idx, 1'b1};
  assign right_m    = left_m + 1'b1;

  assign out_load = (state == S_FIN) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    cur_key_next    = cur_key;
    cur_tag_next    = cur_tag;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_tag_next    = res_tag;
    we              = 1'b0;
    wa              = idx;
    wd              = {cur_tag, cur_key};
    ra0             = par_idx;
    ra1             = IDX_W'(right);
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_key_next = '0;
          res_tag_next = '0;
          if (s_axis_tuser == CMD_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_FIN;
            end else begin
              res_status_next = ST_INSERTED;
              cur_key_next    = in_key;
              cur_tag_next    = in_tag;
              idx_next        = IDX_W'(count);
              count_next      = count + 1'b1;
              ra0             = par_cnt;
              state_next      = S_UP;
            end
          end else begin
            if (count == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_FIN;
            end else begin
              res_status_next = ST_MIN;
              ra0             = '0;
              ra1             = IDX_W'(count - 1'b1);
              count_next      = count - 1'b1;
              state_next      = S_DN_LOAD;
            end
          end
        end
      end
      S_UP: begin
        we = 1'b1;
        if (idx == '0 || !($signed(cur_key) < $signed(rd0_key))) begin
          state_next = S_FIN;
        end else begin
          // shift the parent down and climb
          wd       = rd0;
          idx_next = par_idx;
          ra0      = (par_idx - 1'b1) >> 1;
        end
      end
      S_DN_LOAD: begin
        res_key_next = rd0_key;
        res_tag_next = rd0[ENTRY_W-1:KEY_W];
        cur_key_next = rd1_key;
        cur_tag_next = rd1[ENTRY_W-1:KEY_W];
        idx_next     = '0;
        ra0          = IDX_W'(CH_W'(1));
        ra1          = IDX_W'(CH_W'(2));
        if (count == '0) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_DOWN: begin
        we = 1'b1;
        if (left >= count_ext || !($signed(child_key) < $signed(cur_key))) begin
          state_next = S_FIN;
        end else begin
          // lift the smaller child and descend
          wd       = pick_right ? rd1 : rd0;
          idx_next = m_idx;
          ra0      = IDX_W'(left_m);
          ra1      = IDX_W'(right_m);
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra0 (ra0),
    .ra1 (ra1),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cur_key    <= cur_key_next;
    cur_tag    <= cur_tag_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_tag    <= res_tag_next;
    if (out_load) begin
      m_axis_tdata <= {1'b0, OCC_W'(count), res_tag, res_key};
      m_axis_tuser <= res_status;
    end
  end

endmodule

`default_nettype wire
